// ===== src/rgbh_pkg.sv =====
// Shared constants for the RGB histogram accumulator.
// No dependencies; imported by the top level and the checks.
package rgbh_pkg;

    // Width of one color component and of a bin number on the ports.
    localparam int COMP_W = 8;

    // Number of color channels: red, green, blue.
    localparam int NUM_CH = 3;

    // Channel slots.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Item mode codes.
    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_READ  = 1'b1
    } mode_t;

endpackage

// ===== src/rgbh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; instantiated once per color channel by the top level.
module rgbh_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a same-address read returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rgb_histogram_accumulator_top.sv =====
// Channel  | Direction | Handshake                  | Payload
// pixel    | in        | pixel_valid / pixel_stall  | mode, first_pixel, red, green, blue, bin_index
// result   | out       | result_valid / result_stall| bin_number, red/green/blue/peak_count
//
// Items are taken one per cycle while pixel_stall is low; each bin memory is read at
// the accept edge and written back in the following cycle, with a one-deep bypass for
// back-to-back hits. A pixel marked first of frame stalls the input during one sweep
// of the bin memories writing zero, then while the held pixel is counted.
// After reset the same sweep runs before the first item is taken.
// A read item needs a free slot in the two-entry result queue; result_stall
// only holds the input back when both slots are spoken for.
//
// RGB histogram accumulator top level. Depends on rgbh_pkg and rgbh_ram.
module rgb_histogram_accumulator_top #(
    parameter int BIN_COUNT  = 256,
    parameter int COUNT_BITS = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic                          mode,
    input  logic                          first_pixel,
    input  logic [rgbh_pkg::COMP_W-1:0]   red,
    input  logic [rgbh_pkg::COMP_W-1:0]   green,
    input  logic [rgbh_pkg::COMP_W-1:0]   blue,
    input  logic [rgbh_pkg::COMP_W-1:0]   bin_index,

    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [rgbh_pkg::COMP_W-1:0]   bin_number,
    output logic [COUNT_BITS-1:0]         red_count,
    output logic [COUNT_BITS-1:0]         green_count,
    output logic [COUNT_BITS-1:0]         blue_count,
    output logic [COUNT_BITS-1:0]         peak_count
);

    import rgbh_pkg::*;

    localparam int ADDR_W = $clog2(BIN_COUNT);
    localparam int CMP_W  = (ADDR_W > COMP_W) ? ADDR_W : COMP_W;
    localparam logic [CMP_W-1:0]      LAST_BIN  = CMP_W'(BIN_COUNT - 1);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(BIN_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_INJECT,
        ST_RUN
    } state_t;

    // Map a component or bin index to a memory address, clamping to the last bin.
    function automatic logic [ADDR_W-1:0] bin_of(input logic [COMP_W-1:0] c);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(c);
        if (ext > LAST_BIN)
        begin
            ext = LAST_BIN;
        end
        return ext[ADDR_W-1:0];
    endfunction

    // Control state.
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              hold_valid_reg, hold_valid_next;

    // Held first-of-frame pixel.
    logic [COMP_W-1:0] hold_comp_reg [NUM_CH];

    // Stage 1: item whose memory data is arriving.
    logic              s1_valid_reg;
    logic              s1_read_reg;
    logic              s1_oor_reg;
    logic [COMP_W-1:0] s1_bin_reg;
    logic [ADDR_W-1:0] s1_addr_reg [NUM_CH];
    logic              fwd_hit_reg [NUM_CH];
    logic [COUNT_BITS-1:0] fwd_data_reg [NUM_CH];

    logic [COUNT_BITS-1:0] peak_reg, peak_next;

    // Result queue, two entries.
    logic              q_head_reg;
    logic [1:0]        q_count_reg, q_count_next;
    logic [COMP_W-1:0]     q_bin_reg  [2];
    logic [COUNT_BITS-1:0] q_cnt_reg  [2][NUM_CH];
    logic [COUNT_BITS-1:0] q_peak_reg [2];

    // Datapath signals.
    logic              in_accept;
    logic              start_clear;
    logic              enter_s1;
    logic              enter_read;
    logic [ADDR_W-1:0] new_addr [NUM_CH];
    logic [COMP_W-1:0] in_comp [NUM_CH];
    logic [COUNT_BITS-1:0] rd_data  [NUM_CH];
    logic [COUNT_BITS-1:0] cur_val  [NUM_CH];
    logic [COUNT_BITS-1:0] inc_val  [NUM_CH];
    logic [COUNT_BITS-1:0] res_val  [NUM_CH];
    logic              s1_pixel;
    logic              q_push;
    logic              q_pop;
    logic              q_tail;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr [NUM_CH];
    logic [COUNT_BITS-1:0] mem_wdata [NUM_CH];

    assign in_comp[CH_RED]   = red;
    assign in_comp[CH_GREEN] = green;
    assign in_comp[CH_BLUE]  = blue;

    // Input flow control: no items during a sweep, and room must exist for a read result.
    assign pixel_stall = (state_reg != ST_RUN)
                      || ((3'(q_count_reg) + 3'(s1_valid_reg && s1_read_reg)) >= 3'd2);
    assign in_accept   = pixel_valid && !pixel_stall;
    assign start_clear = in_accept && (mode == MODE_PIXEL) && first_pixel;
    assign enter_s1    = (in_accept && !start_clear) || (state_reg == ST_INJECT);
    assign enter_read  = in_accept && (mode == MODE_READ);

    // Memory read addresses: the held pixel when injecting, otherwise the port.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (state_reg == ST_INJECT)
            begin
                new_addr[ch] = bin_of(hold_comp_reg[ch]);
            end
            else if (mode == MODE_READ)
            begin
                new_addr[ch] = bin_of(bin_index);
            end
            else
            begin
                new_addr[ch] = bin_of(in_comp[ch]);
            end
        end
    end

    // Stage 1 arithmetic: bypass, saturating increment, zeroing of out-of-range reads.
    assign s1_pixel = s1_valid_reg && !s1_read_reg;
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            cur_val[ch] = fwd_hit_reg[ch] ? fwd_data_reg[ch] : rd_data[ch];
            inc_val[ch] = (cur_val[ch] == COUNT_MAX) ? cur_val[ch]
                                                     : cur_val[ch] + COUNT_BITS'(1);
            res_val[ch] = s1_oor_reg ? '0 : cur_val[ch];
        end
    end

    // Memory write port: sweep zeros during a clear, otherwise write back.
    assign mem_we = s1_pixel || (state_reg == ST_CLEAR);
    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (state_reg == ST_CLEAR)
            begin
                mem_waddr[ch] = clr_cnt_reg;
                mem_wdata[ch] = '0;
            end
            else
            begin
                mem_waddr[ch] = s1_addr_reg[ch];
                mem_wdata[ch] = inc_val[ch];
            end
        end
    end

    // One bin memory per channel.
    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_bins
        rgbh_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (BIN_COUNT)
        ) u_bins (
            .clk   (clk),
            .we    (mem_we),
            .waddr (mem_waddr[g]),
            .wdata (mem_wdata[g]),
            .raddr (new_addr[g]),
            .rdata (rd_data[g])
        );
    end

    // Peak tracking: reset to one during a clear, raised by each counted pixel.
    always_comb
    begin
        peak_next = peak_reg;
        if (state_reg == ST_CLEAR)
        begin
            peak_next = COUNT_BITS'(1);
        end
        else if (s1_pixel)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (inc_val[ch] > peak_next)
                begin
                    peak_next = inc_val[ch];
                end
            end
        end
    end

    // Sweep sequencer next state.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        hold_valid_next = hold_valid_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (start_clear)
                begin
                    state_next      = ST_CLEAR;
                    clr_cnt_next    = '0;
                    hold_valid_next = 1'b1;
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = hold_valid_reg ? ST_INJECT : ST_RUN;
                end
            end
            ST_INJECT:
            begin
                state_next      = ST_RUN;
                hold_valid_next = 1'b0;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Result queue control.
    assign q_push = s1_valid_reg && s1_read_reg;
    assign q_pop  = result_valid && !result_stall;
    assign q_tail = q_head_reg ^ q_count_reg[0];
    always_comb
    begin
        q_count_next = q_count_reg;
        if (q_push && !q_pop)
        begin
            q_count_next = q_count_reg + 2'd1;
        end
        else if (q_pop && !q_push)
        begin
            q_count_next = q_count_reg - 2'd1;
        end
    end

    // Control registers of stage 1, peak and queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            peak_reg     <= COUNT_BITS'(1);
            q_head_reg   <= 1'b0;
            q_count_reg  <= '0;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                fwd_hit_reg[ch] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg <= enter_s1;
            peak_reg     <= peak_next;
            q_count_reg  <= q_count_next;
            if (q_pop)
            begin
                q_head_reg <= ~q_head_reg;
            end
            // Bypass when the new item hits the entry written back at this edge.
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                fwd_hit_reg[ch] <= enter_s1 && s1_pixel
                                && (s1_addr_reg[ch] == new_addr[ch]);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (start_clear)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                hold_comp_reg[ch] <= in_comp[ch];
            end
        end
        if (enter_s1)
        begin
            s1_read_reg <= enter_read;
            s1_oor_reg  <= CMP_W'(bin_index) > LAST_BIN;
            s1_bin_reg  <= bin_index;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                s1_addr_reg[ch] <= new_addr[ch];
            end
        end
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            fwd_data_reg[ch] <= inc_val[ch];
        end
        if (q_push)
        begin
            q_bin_reg[q_tail]  <= s1_bin_reg;
            q_peak_reg[q_tail] <= peak_reg;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                q_cnt_reg[q_tail][ch] <= res_val[ch];
            end
        end
    end

    // Result port.
    assign result_valid = (q_count_reg != 2'd0);
    assign bin_number   = q_bin_reg[q_head_reg];
    assign red_count    = q_cnt_reg[q_head_reg][CH_RED];
    assign green_count  = q_cnt_reg[q_head_reg][CH_GREEN];
    assign blue_count   = q_cnt_reg[q_head_reg][CH_BLUE];
    assign peak_count   = q_peak_reg[q_head_reg];

endmodule

// ===== src/rgbh_checks.sv =====
// Port-level checks for the RGB histogram accumulator, bound to the top level.
// Depends on rgbh_pkg and rgb_histogram_accumulator_top.
module rgbh_checks #(
    parameter int COUNT_BITS = 22
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_valid,
    input logic                        pixel_stall,
    input logic                        mode,
    input logic                        first_pixel,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [rgbh_pkg::COMP_W-1:0] bin_number,
    input logic [COUNT_BITS-1:0]       red_count,
    input logic [COUNT_BITS-1:0]       green_count,
    input logic [COUNT_BITS-1:0]       blue_count,
    input logic [COUNT_BITS-1:0]       peak_count
);

    import rgbh_pkg::*;

    // A first-of-frame pixel starts the clearing sweep, so the input stalls next.
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall && (mode == MODE_PIXEL) && first_pixel)
        |=> pixel_stall)
        else $error("input not stalled after first-of-frame pixel");

    // Coming out of reset the bins are being cleared.
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> pixel_stall)
        else $error("input open while reset sweep runs");

    // The peak never drops below one.
    a_peak_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (peak_count != '0))
        else $error("peak count is zero");

    // No reported bin exceeds the peak taken at the same time.
    a_counts_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((red_count <= peak_count) && (green_count <= peak_count)
                          && (blue_count <= peak_count)))
        else $error("bin count above peak");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(bin_number)
                                            && $stable(peak_count)))
        else $error("stalled result changed");

endmodule

bind rgb_histogram_accumulator_top rgbh_checks #(
    .COUNT_BITS (COUNT_BITS)
) u_rgbh_checks (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .mode         (mode),
    .first_pixel  (first_pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .bin_number   (bin_number),
    .red_count    (red_count),
    .green_count  (green_count),
    .blue_count   (blue_count),
    .peak_count   (peak_count)
);
